>>> hdl/taysin_pkg.sv
// shared types, constants and the reciprocal table of the taylor sine block
`timescale 1ns / 1ps

package taysin_pkg;

  // field widths
  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 32;
  localparam int TC_W    = 4;

  // register reset and series length limit
  localparam logic [TC_W-1:0] TC_RESET = 4'd8;
  localparam int MAX_TERMS_DEF = 12;

  // pi and 2*pi in q8.24
  localparam logic [ANGLE_W-1:0] PI_Q24     = 32'd52707179;
  localparam logic [ANGLE_W-1:0] TWO_PI_Q24 = 32'd105414357;

  // range reduction: quotient below 32, one compare and subtract per bit
  localparam int RED_STEPS = 5;
  localparam int RED_CNT_W = 3;

  // datapath widths
  localparam int MX_W      = 30;          // |x| in q4.28
  localparam int RED_MAG_W = MX_W - 4;    // |r| in q8.24
  localparam int MAG_W     = 31;          // term magnitude in q4.28
  localparam int X2_W      = 32;          // x^2 in q4.28
  localparam int T_W       = 35;          // term times x^2, before the reciprocal
  localparam int MUL_A_W   = 35;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SUM_W     = 36;

  // sequencer states
  typedef enum logic [3:0] {
    CS_IDLE,
    CS_RED,
    CS_SQ,
    CS_X2,
    CS_ACC,
    CS_MUL1,
    CS_RND1,
    CS_MUL2,
    CS_RND2,
    CS_DONE
  } core_state_t;

  // folded angle from the range reducer
  typedef struct packed {
    logic            neg;
    logic [MX_W-1:0] mx;
  } rred_res_t;

  // one finished result
  typedef struct packed {
    logic [OUT_W-1:0] sine_value;
    logic             saturated;
  } sine_res_t;

  // round(2^32 / ((2i+2)(2i+3))), zero beyond the table
  function automatic logic [MUL_B_W-1:0] recip_lookup(input logic [TC_W-1:0] idx);
    logic [MUL_B_W-1:0] val;
    case (idx)
      4'd0:    val = 32'd715827883;
      4'd1:    val = 32'd214748365;
      4'd2:    val = 32'd102261126;
      4'd3:    val = 32'd59652324;
      4'd4:    val = 32'd39045157;
      4'd5:    val = 32'd27531842;
      4'd6:    val = 32'd20452225;
      4'd7:    val = 32'd15790321;
      4'd8:    val = 32'd12558384;
      4'd9:    val = 32'd10226113;
      4'd10:   val = 32'd8488078;
      4'd11:   val = 32'd7158279;
      4'd12:   val = 32'd6118187;
      4'd13:   val = 32'd5289369;
      4'd14:   val = 32'd4618244;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hdl/taysin_mul.sv
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module taysin_mul (
  input  logic                           clk,
  input  logic [taysin_pkg::MUL_A_W-1:0] mul_a,
  input  logic [taysin_pkg::MUL_B_W-1:0] mul_b,
  output logic [taysin_pkg::PROD_W-1:0]  prod
);
  import taysin_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

>>> hdl/taysin_rred.sv
// range reduction of the angle modulo 2*pi and fold into [-pi, pi]
`timescale 1ns / 1ps

module taysin_rred (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [taysin_pkg::ANGLE_W-1:0] angle,
  output logic                           done,
  output taysin_pkg::rred_res_t          res
);
  import taysin_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [RED_CNT_W-1:0] j_r;
  logic [ANGLE_W-1:0]   rem_r;
  logic [ANGLE_W-1:0]   rem_nxt;
  logic                 sgn_r;
  logic [ANGLE_W-1:0]   abs_angle;
  logic [ANGLE_W-1:0]   dsr;
  logic                 fold;
  logic [ANGLE_W-1:0]   folded;

  // magnitude of the incoming angle, most negative value included
  assign abs_angle = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;

  // one restoring step against 2*pi shifted by the current quotient bit
  always_comb begin
    dsr = TWO_PI_Q24 << j_r;
    rem_nxt = (rem_r >= dsr) ? (rem_r - dsr) : rem_r;
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      j_r    <= '0;
    end else begin
      done_r <= busy_r && (j_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        j_r    <= RED_CNT_W'(RED_STEPS - 1);
      end else if (busy_r) begin
        if (j_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          j_r <= j_r - 1'b1;
        end
      end
    end
  end

  // remainder register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= abs_angle;
      sgn_r <= angle[ANGLE_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  // fold above pi, the sign flipping with it
  always_comb begin
    fold   = rem_r > PI_Q24;
    folded = fold ? (TWO_PI_Q24 - rem_r) : rem_r;
  end

  assign done    = done_r;
  assign res.neg = sgn_r ^ fold;
  assign res.mx  = {folded[RED_MAG_W-1:0], 4'b0000};

`ifndef SYNTHESIS
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < TWO_PI_Q24))
    else $error("remainder not below 2*pi at end of reduction");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (j_r == '0) && !start) |=> (done_r && !busy_r))
    else $error("reduction did not finish after its last step");
`endif

endmodule

>>> hdl/taysin_core.sv
// sequencer that sums the sine series on the shared multiplier
`timescale 1ns / 1ps

module taysin_core #(
  parameter int MAX_TERMS = taysin_pkg::MAX_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [taysin_pkg::ANGLE_W-1:0] angle,
  input  logic [taysin_pkg::TC_W-1:0]    term_count,
  output logic                           idle,
  input  logic                           res_ready,
  output logic                           res_valid,
  output taysin_pkg::sine_res_t          res
);
  import taysin_pkg::*;

  localparam logic [TC_W:0]     MAX_T  = (TC_W + 1)'(MAX_TERMS);
  localparam logic [PROD_W-1:0] HALF28 = PROD_W'(1) << 27;
  localparam logic [PROD_W-1:0] HALF32 = PROD_W'(1) << 31;

  core_state_t state_r, state_nxt;

  logic [TC_W-1:0]         n_r;
  logic [TC_W-1:0]         k_r;
  logic [TC_W-1:0]         n_sel;
  logic                    neg_r;
  logic [MAG_W-1:0]        mag_r;
  logic [X2_W-1:0]         x2_r;
  logic [T_W-1:0]          t_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] mag_ext;
  logic                    tneg;
  logic                    more;
  logic                    fits;

  logic                    rred_done;
  rred_res_t               rred_res;

  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       prod_h28;
  logic [PROD_W-1:0]       prod_h32;

  taysin_rred u_rred (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && idle),
    .angle (angle),
    .done  (rred_done),
    .res   (rred_res)
  );

  taysin_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  // clamp the term count to the series limit
  assign n_sel = ({1'b0, term_count} > MAX_T) ? MAX_T[TC_W-1:0] : term_count;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state_r)
      CS_SQ: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(mag_r);
      end
      CS_MUL1: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = x2_r;
      end
      CS_MUL2: begin
        mul_a = t_r;
        mul_b = recip_lookup(k_r - 1'b1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding half up of the registered product
  assign prod_h28 = prod + HALF28;
  assign prod_h32 = prod + HALF32;

  // signed accumulation of the current term
  always_comb begin
    tneg    = neg_r ^ k_r[0];
    mag_ext = signed'(SUM_W'(mag_r));
    sum_nxt = tneg ? (sum_r - mag_ext) : (sum_r + mag_ext);
    more    = (({1'b0, k_r}) + 1'b1) < {1'b0, n_r};
  end

  // clip the sum to 32 bits
  always_comb begin
    fits = (&sum_r[SUM_W-1:OUT_W-1]) || !(|sum_r[SUM_W-1:OUT_W-1]);
    res.saturated = !fits;
    if (fits) begin
      res.sine_value = sum_r[OUT_W-1:0];
    end else if (sum_r[SUM_W-1]) begin
      res.sine_value = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res.sine_value = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    idle      = (state_r == CS_IDLE);
    res_valid = (state_r == CS_DONE) && res_ready;
    unique case (state_r)
      CS_IDLE: if (start) state_nxt = CS_RED;
      CS_RED:  if (rred_done) state_nxt = CS_SQ;
      CS_SQ:   state_nxt = CS_X2;
      CS_X2:   state_nxt = (n_r == '0) ? CS_DONE : CS_ACC;
      CS_ACC:  state_nxt = more ? CS_MUL1 : CS_DONE;
      CS_MUL1: state_nxt = CS_RND1;
      CS_RND1: state_nxt = CS_MUL2;
      CS_MUL2: state_nxt = CS_RND2;
      CS_RND2: state_nxt = CS_ACC;
      CS_DONE: if (res_ready) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  // term counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      k_r <= '0;
    end else if ((state_r == CS_IDLE) && start) begin
      n_r <= n_sel;
      k_r <= '0;
    end else if ((state_r == CS_ACC) && more) begin
      k_r <= k_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == CS_IDLE) && start) begin
      sum_r <= '0;
    end
    if ((state_r == CS_RED) && rred_done) begin
      mag_r <= MAG_W'(rred_res.mx);
      neg_r <= rred_res.neg;
    end
    if (state_r == CS_X2) begin
      x2_r <= prod_h28[28 +: X2_W];
    end
    if (state_r == CS_ACC) begin
      sum_r <= sum_nxt;
    end
    if (state_r == CS_RND1) begin
      t_r <= prod_h28[28 +: T_W];
    end
    if (state_r == CS_RND2) begin
      mag_r <= prod_h32[32 +: MAG_W];
    end
  end

`ifndef SYNTHESIS
  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_MUL1) |-> (({1'b0, k_r} < {1'b0, n_r}) && (k_r != '0)))
    else $error("term index outside the series");

  a_red_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    rred_done |-> (state_r == CS_RED))
    else $error("range reduction finished with no item waiting for it");

  a_first_term_after_square: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == CS_ACC) && (k_r == '0)) |-> ($past(state_r) == CS_X2))
    else $error("first term summed before x^2 was formed");
`endif

endmodule

>>> hdl/taylor_sine.sv
// top level of the taylor sine block: stream ports, register and result stage
//
//  channel | direction | fields (low bit up)             | accepted when
//  in_     | slave     | tdata: angle q8.24 [31:0]        | in_tvalid & in_tready
//  out_    | master    | tdata: sine_value q4.28 [31:0]   | out_tvalid & out_tready
//          |           | tuser: saturated [0]             |
//  cfg_    | write     | wdata: term_count [3:0]          | cfg_wen
//
// an angle passes from acceptance through the range reduction, the squaring
// and one accumulate per term to its result, term_count being limited to
// MAX_TERMS; the reduction takes 5 compare-subtract steps and each further
// term passes through MUL1, RND1, MUL2 and RND2 on the one multiplier plus one
// accumulate. one angle is in work at a time; a result waiting in the output
// stage does not hold off the next angle. reset is synchronous, active low, and sets term_count to 8.
`timescale 1ns / 1ps

module taylor_sine #(
  parameter int MAX_TERMS = taysin_pkg::MAX_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wen,
  input  logic [taysin_pkg::TC_W-1:0]    cfg_wdata,   // term_count
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [taysin_pkg::ANGLE_W-1:0] in_tdata,    // angle
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [taysin_pkg::OUT_W-1:0]   out_tdata,   // sine_value
  output logic                           out_tuser    // saturated
);
  import taysin_pkg::*;

  logic [TC_W-1:0]  term_count_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_sat_r;
  logic             core_idle;
  logic             core_res_ready;
  logic             core_res_valid;
  sine_res_t        core_res;

  taysin_core #(
    .MAX_TERMS (MAX_TERMS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_tvalid && in_tready),
    .angle      (in_tdata),
    .term_count (term_count_r),
    .idle       (core_idle),
    .res_ready  (core_res_ready),
    .res_valid  (core_res_valid),
    .res        (core_res)
  );

  assign in_tready      = core_idle;
  assign core_res_ready = !out_valid_r || out_tready;

  // term count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TC_RESET;
    end else if (cfg_wen) begin
      term_count_r <= cfg_wdata;
    end
  end

  // output stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (core_res_valid) begin
      out_data_r <= core_res.sine_value;
      out_sat_r  <= core_res.saturated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    core_res_valid |-> (!out_valid_r || out_tready))
    else $error("result written over one not yet taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again while an angle is in work");
`endif

endmodule

>>> bench/testbench.sv
// self-checking bench for taylor_sine: directed angle table, then random angles
`timescale 1ns / 1ps

module testbench;
  import taysin_pkg::*;

  localparam int HALF_NS       = 5;
  localparam int STALL_PCT     = 38;
  localparam int RANDOM_ANGLES = 450;
  localparam int IDLE_LIMIT    = 3000;
  // settle time that leaves margin beyond the slowest angle after the last result
  localparam int SETTLE_CYCLES = 80;

  // round(2^32 / ((2i+2)(2i+3))) in q0.32, one entry per series step
  localparam bit [31:0] INV_FACT [15] = '{
    32'd715827883, 32'd214748365, 32'd102261126, 32'd59652324, 32'd39045157,
    32'd27531842,  32'd20452225,  32'd15790321,  32'd12558384, 32'd10226113,
    32'd8488078,   32'd7158279,   32'd6118187,   32'd5289369,  32'd4618244
  };

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [TC_W-1:0]    terms;
    logic [ANGLE_W-1:0] angle;
    logic               typed;
    logic [OUT_W-1:0]   want_val;
    logic               want_sat;
  } plan_row_t;

  localparam int PLAN_N = 24;
  localparam plan_row_t PLAN [PLAN_N] = '{
    // reset series length, angle extremes and the fold boundaries
    '{4'd8,  32'd0,                1'b1, 32'd0,         1'b0},
    '{4'd8,  32'h7FFFFFFF,         1'b0, 32'd0,         1'b0},
    '{4'd8,  32'h80000000,         1'b0, 32'd0,         1'b0},
    '{4'd8,  PI_Q24,               1'b0, 32'd0,         1'b0},
    '{4'd8,  -PI_Q24,              1'b0, 32'd0,         1'b0},
    '{4'd8,  PI_Q24 + 32'd1,       1'b0, 32'd0,         1'b0},
    '{4'd8,  -PI_Q24 - 32'd1,      1'b0, 32'd0,         1'b0},
    '{4'd8,  TWO_PI_Q24,           1'b1, 32'd0,         1'b0},
    '{4'd8,  -TWO_PI_Q24,          1'b1, 32'd0,         1'b0},
    '{4'd8,  32'd1,                1'b0, 32'd0,         1'b0},
    '{4'd8,  32'hFFFFFFFF,         1'b0, 32'd0,         1'b0},
    '{4'd8,  32'h01000000,         1'b0, 32'd0,         1'b0},
    // zero terms always sums to nothing
    '{4'd0,  32'h12345678,         1'b1, 32'd0,         1'b0},
    '{4'd0,  32'h80000000,         1'b1, 32'd0,         1'b0},
    // one term returns x itself in q4.28
    '{4'd1,  32'h01000000,         1'b1, 32'h10000000,  1'b0},
    '{4'd1,  32'hFF000000,         1'b1, 32'hF0000000,  1'b0},
    '{4'd1,  32'h7FFFFFFF,         1'b0, 32'd0,         1'b0},
    // longest series, and counts above the limit
    '{4'd12, PI_Q24,               1'b0, 32'd0,         1'b0},
    '{4'd12, 32'h01921FB5,         1'b0, 32'd0,         1'b0},
    '{4'd12, 32'h80000000,         1'b0, 32'd0,         1'b0},
    '{4'd15, PI_Q24,               1'b0, 32'd0,         1'b0},
    '{4'd15, 32'h01921FB5,         1'b0, 32'd0,         1'b0},
    '{4'd13, 32'hFE6DE04B,         1'b0, 32'd0,         1'b0},
    // two terms give the widest negative partial sum at pi
    '{4'd2,  PI_Q24,               1'b0, 32'd0,         1'b0}
  };

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_wen    = 1'b0;
  logic [TC_W-1:0]     cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic [ANGLE_W-1:0]  in_tdata   = '0;
  logic                out_tready = 1'b0;
  logic                in_tready;
  logic                out_tvalid;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tuser;

  logic                steady     = 1'b0;
  logic [TC_W-1:0]     term_setting = TC_RESET;
  sine_res_t           sine_q[$];
  int                  err_count    = 0;
  int                  angles_sent  = 0;
  int                  results_seen = 0;
  int                  cfg_writes   = 0;
  int                  idle_cycles  = 0;

  taylor_sine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  // half-up rounding right shift on a magnitude
  function automatic bit [63:0] round_off(input bit [63:0] v, input int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  // expected sine and flag for one angle under a given series length
  function automatic sine_res_t sine_predict(input logic [ANGLE_W-1:0] angle,
                                             input logic [TC_W-1:0] terms);
    longint    a, r, total;
    bit [63:0] mx, x2, mag;
    int        n;
    bit        neg;
    sine_res_t res;
    // reduce modulo 2*pi, remainder signed like the angle, then fold into [-pi, pi]
    a = longint'($signed(angle));
    r = a % longint'(TWO_PI_Q24);
    if (r > longint'(PI_Q24)) begin
      r -= longint'(TWO_PI_Q24);
    end else if (r < -longint'(PI_Q24)) begin
      r += longint'(TWO_PI_Q24);
    end
    neg = (r < 0);
    mx  = neg ? -r : r;
    mx  = mx * 64'd16;
    x2  = round_off(mx * mx, 28);
    n   = (terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(terms);
    // series terms on the magnitude, sign alternating
    mag   = mx;
    total = 0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        if (k - 1 < 15) begin
          mag = round_off(round_off(mag * x2, 28) * INV_FACT[k-1], 32);
        end else begin
          mag = 64'd0;
        end
      end
      if (neg ^ (k % 2 == 1)) begin
        total -= longint'(mag);
      end else begin
        total += longint'(mag);
      end
    end
    // clip to q4.28
    if (total > 64'sd2147483647) begin
      res.sine_value = 32'h7FFFFFFF;
      res.saturated  = 1'b1;
    end else if (total < -64'sd2147483648) begin
      res.sine_value = 32'h80000000;
      res.saturated  = 1'b1;
    end else begin
      res.sine_value = total[31:0];
      res.saturated  = 1'b0;
    end
    return res;
  endfunction

  // random angle: mostly full range or inside one turn, some near fold points and extremes
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int     kind, m, off;
    longint v;
    kind = $urandom_range(0, 99);
    off  = int'($urandom_range(0, 16)) - 8;
    if (kind < 40) begin
      v = longint'($urandom);
    end else if (kind < 65) begin
      v = longint'($urandom_range(0, 2 * PI_Q24)) - longint'(PI_Q24);
    end else if (kind < 80) begin
      m = int'($urandom_range(0, 80)) - 40;
      v = longint'(m) * longint'(PI_Q24) + off;
    end else if (kind < 90) begin
      m = int'($urandom_range(0, 38)) - 19;
      v = longint'(m) * longint'(TWO_PI_Q24) + off
          + ($urandom_range(0, 1) ? longint'(PI_Q24) : -longint'(PI_Q24));
    end else if ($urandom_range(0, 1)) begin
      v = longint'(32'h7FFFFFFF) - longint'($urandom_range(0, 15));
    end else begin
      v = -longint'(32'h80000000) + longint'($urandom_range(0, 15));
    end
    return v[31:0];
  endfunction

  // one line per mismatch, counted
  task automatic report_miss(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h, wanted %h", $time, what, got, want);
    err_count++;
  endtask

  // offer one angle request, with random gaps unless steady, and queue its result once taken
  task automatic send_angle(input logic [ANGLE_W-1:0] angle, input sine_res_t want);
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sine_q.push_back(want);
    angles_sent++;
  endtask

  // hold off requests until every queued result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sine_q.size() != 0) @(posedge clk);
  endtask

  // new series length, written only with the block idle
  task automatic write_term(input logic [TC_W-1:0] v);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen      <= 1'b0;
    term_setting = v;
    cfg_writes++;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // score each result against the oldest expectation
  always @(posedge clk) begin : result_check
    sine_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (sine_q.size() == 0) begin
        report_miss("result with no request outstanding", out_tdata, '0);
      end else begin
        want = sine_q.pop_front();
        if (out_tdata !== want.sine_value) begin
          report_miss("sine_value", out_tdata, want.sine_value);
        end
        if (out_tuser !== want.saturated) begin
          report_miss("saturated", {31'd0, out_tuser}, {31'd0, want.saturated});
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int                 phase_left;
    logic [ANGLE_W-1:0] a;
    sine_res_t          want;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, first rows under the reset series length
    for (int i = 0; i < PLAN_N; i++) begin
      if (PLAN[i].terms != term_setting) begin
        write_term(PLAN[i].terms);
      end
      if (PLAN[i].typed) begin
        want.sine_value = PLAN[i].want_val;
        want.saturated  = PLAN[i].want_sat;
      end else begin
        want = sine_predict(PLAN[i].angle, term_setting);
      end
      send_angle(PLAN[i].angle, want);
    end

    // random phases, each under its own series length
    phase_left = 0;
    for (int i = 0; i < RANDOM_ANGLES; i++) begin
      if (phase_left == 0) begin
        write_term(TC_W'($urandom_range(0, 15)));
        phase_left = $urandom_range(15, 50);
      end
      steady <= (i >= 200 && i < 300);
      // occasional full drain mid phase
      if ($urandom_range(0, 59) == 0) begin
        wait_idle();
      end
      a = pick_angle();
      send_angle(a, sine_predict(a, term_setting));
      phase_left--;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sine_q.size() != 0) begin
      report_miss("results never delivered", sine_q.size(), 32'd0);
    end
    $display("run covered %0d angles and %0d results over %0d series length writes,",
             angles_sent, results_seen, cfg_writes);
    $display("including a stall-free stretch and drained pauses; %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
